/* rtl/ddd_pkg.sv */
// ddd_pkg: item types, calendar constants and month-length helpers
// for the date difference block; no dependencies
`default_nettype none
package ddd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;
  localparam int REM_W   = 9;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [YEAR_W-1:0] CYCLE_YEARS = 14'd400;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
  localparam logic [DAY_W-1:0] FEB_LEAP_LEN = 5'd29;
  localparam logic [COUNT_W-1:0] YEAR_LEN = 22'd365;

  localparam logic [DAY_W-1:0] MONTH_LEN [0:11] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               bad_date;
  } out_item_t;

  // leap from the year's two low bits and its remainder mod 400
  function automatic logic is_leap(input logic [1:0] y_lo, input logic [REM_W-1:0] r400);
    logic century;
    century = (r400 == 9'd0) || (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
    return (y_lo == 2'd0) && (!century || (r400 == 9'd0));
  endfunction

  // length of a month, 0 for a month out of range
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = '0;
    if (m >= 4'd1 && m <= MONTH_MAX) begin
      len = MONTH_LEN[m - 4'd1];
      if (m == MONTH_FEB && leap) begin
        len = FEB_LEAP_LEN;
      end
    end
    return len;
  endfunction

endpackage
`default_nettype wire

/* rtl/date_difference_in_days.sv */
// date_difference_in_days: day count between two Gregorian dates
// one shared add/subtract unit under a small sequencer; uses ddd_pkg
// steps: years mod 400, date check, end day plus year lengths from start to end year,
// plus end-year months before end month, less start-year months before start month,
// less start day; a bad date or a start not earlier gives 0; one item at a time
// reset: synchronous, clears the sequencer and the output valid
`default_nettype none
module date_difference_in_days (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ddd_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ddd_pkg::out_item_t     out_item
);
  import ddd_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MOD_S  = 4'd1;
  localparam logic [3:0] S_MOD_E  = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_YEARS  = 4'd4;
  localparam logic [3:0] S_MON_E  = 4'd5;
  localparam logic [3:0] S_MON_S  = 4'd6;
  localparam logic [3:0] S_DAYS   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  localparam logic [2:0] MOD_TOP = 3'd5;

  logic [3:0]         state;
  in_item_t           item;
  logic [YEAR_W-1:0]  rem;
  logic [REM_W-1:0]   r400_s;
  logic [REM_W-1:0]   r400_e;
  logic [REM_W-1:0]   r400_y;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [2:0]         shift;
  logic [COUNT_W-1:0] acc;
  logic               bad;

  logic [COUNT_W-1:0] op_a;
  logic [COUNT_W-1:0] op_b;
  logic               op_sub;
  logic [COUNT_W:0]   sum;
  logic               leap_s;
  logic               leap_e;
  logic               leap_y;
  logic               ok_s;
  logic               ok_e;
  logic               earlier;
  logic               out_load;

  assign leap_s = is_leap(item.start_year[1:0], r400_s);
  assign leap_e = is_leap(item.end_year[1:0], r400_e);
  assign leap_y = is_leap(year[1:0], r400_y);

  assign ok_s = (item.start_year >= YEAR_MIN) && (item.start_year <= YEAR_MAX) &&
                (item.start_day != '0) &&
                (item.start_day <= month_len(item.start_month, leap_s));
  assign ok_e = (item.end_year >= YEAR_MIN) && (item.end_year <= YEAR_MAX) &&
                (item.end_day != '0) &&
                (item.end_day <= month_len(item.end_month, leap_e));

  assign earlier = (item.start_year < item.end_year) ||
                   ((item.start_year == item.end_year) &&
                    ((item.start_month < item.end_month) ||
                     ((item.start_month == item.end_month) &&
                      (item.start_day < item.end_day))));

  // shared add/subtract unit
  always_comb begin
    op_a   = acc;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (state)
      S_MOD_S, S_MOD_E: begin
        op_a   = {{(COUNT_W-YEAR_W){1'b0}}, rem};
        op_b   = {{(COUNT_W-YEAR_W){1'b0}}, CYCLE_YEARS << shift};
        op_sub = 1'b1;
      end
      S_YEARS: begin
        op_b = YEAR_LEN + {{(COUNT_W-1){1'b0}}, leap_y};
      end
      S_MON_E: begin
        op_b = {{(COUNT_W-DAY_W){1'b0}}, month_len(month, leap_e)};
      end
      S_MON_S: begin
        op_b   = {{(COUNT_W-DAY_W){1'b0}}, month_len(month, leap_s)};
        op_sub = 1'b1;
      end
      S_DAYS: begin
        op_b   = {{(COUNT_W-DAY_W){1'b0}}, item.start_day};
        op_sub = 1'b1;
      end
      default: begin
      end
    endcase
    sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + {{COUNT_W{1'b0}}, op_sub};
  end

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            rem   <= in_item.start_year;
            shift <= MOD_TOP;
            state <= S_MOD_S;
          end
        end
        S_MOD_S, S_MOD_E: begin
          if (shift == 3'd0) begin
            if (state == S_MOD_S) begin
              r400_s <= sum[COUNT_W] ? sum[REM_W-1:0] : rem[REM_W-1:0];
              rem    <= item.end_year;
              shift  <= MOD_TOP;
              state  <= S_MOD_E;
            end else begin
              r400_e <= sum[COUNT_W] ? sum[REM_W-1:0] : rem[REM_W-1:0];
              state  <= S_CHECK;
            end
          end else begin
            if (sum[COUNT_W]) begin
              rem <= sum[YEAR_W-1:0];
            end
            shift <= shift - 3'd1;
          end
        end
        S_CHECK: begin
          bad    <= !(ok_s && ok_e);
          year   <= item.start_year;
          r400_y <= r400_s;
          month  <= 4'd1;
          if (ok_s && ok_e && earlier) begin
            acc   <= {{(COUNT_W-DAY_W){1'b0}}, item.end_day};
            state <= S_YEARS;
          end else begin
            acc   <= '0;
            state <= S_FINISH;
          end
        end
        S_YEARS: begin
          if (year == item.end_year) begin
            state <= S_MON_E;
          end else begin
            acc    <= sum[COUNT_W-1:0];
            year   <= year + 14'd1;
            r400_y <= (r400_y == 9'd399) ? '0 : r400_y + 9'd1;
          end
        end
        S_MON_E: begin
          if (month == item.end_month) begin
            month <= 4'd1;
            state <= S_MON_S;
          end else begin
            acc   <= sum[COUNT_W-1:0];
            month <= month + 4'd1;
          end
        end
        S_MON_S: begin
          if (month == item.start_month) begin
            state <= S_DAYS;
          end else begin
            acc   <= sum[COUNT_W-1:0];
            month <= month + 4'd1;
          end
        end
        S_DAYS: begin
          acc   <= sum[COUNT_W-1:0];
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            out_item.day_count <= acc;
            out_item.bad_date  <= bad;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
